FILE: design/phij_pkg.sv
// Shared types, constants and codes for the peak-and-hold injector pulse unit.
package phij_pkg;

    localparam int CHANNELS    = 4;
    localparam int ADC_W       = 10;
    localparam int TIMER_W     = 17;
    localparam int PWM_W       = 16;
    localparam int STIMER_W    = 10;
    localparam int CH_W        = 2;
    localparam int DRIVE_W     = 4;
    localparam int COUNT_W     = 12;
    localparam int SUM_W       = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int DIV_CNT_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_TIME       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_ON         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE       = 3'd6;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CH_W-1:0]   channel;
        logic              peak_hold;
        logic [ADC_W-1:0]  adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               busy_res;
        logic               done_res;
        logic               rejected;
        logic [ADC_W-1:0]   peak_counts;
        logic [ADC_W-1:0]   avg_counts;
        logic [COUNT_W-1:0] sample_count;
    } out_item_t;

    typedef struct packed {
        logic step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
    } status_t;

endpackage

FILE: design/peak_hold_injector_pulse_unit.sv
// Top level of the peak-and-hold injector pulse unit.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    in_data   (in_item_t)
//   out      from block out_valid / out_stall  out_data  (out_item_t)
//   cfg      to block   cfg_we                 cfg_index, cfg_wdata
//
// An item is accepted, then loaded into the output register. An item that ends
// a firing with samples waits in between, in the divide state, for the
// bit-serial divider that forms the average (one quotient bit per cycle over
// the 22-bit sum) to finish. The output register lets the next item be
// accepted while a result waits; a held result stalls the next load.
// Reset is asynchronous and loads the register defaults; no clearing pass.
module peak_hold_injector_pulse_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  phij_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output phij_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [phij_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phij_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import phij_pkg::*;

    cmd_t    cmd;
    status_t status;

    phij_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    phij_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

FILE: design/phij_div.sv
// Restoring divider, one quotient bit per cycle, for the average current.
module phij_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [phij_pkg::SUM_W-1:0]     dividend,
    input  logic [phij_pkg::COUNT_W-1:0]   divisor,
    output logic                           busy,
    output logic [phij_pkg::ADC_W-1:0]     quotient
);
    import phij_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [COUNT_W-1:0]    dvs_reg, dvs_next;
    logic [COUNT_W:0]      shifted;
    logic [COUNT_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[COUNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[COUNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[ADC_W-1:0];

endmodule

FILE: design/phij_dp.sv
// Datapath: configuration registers, firing timers, current statistics and result register.
module phij_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [phij_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phij_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  phij_pkg::in_item_t                in_data,
    input  phij_pkg::cmd_t                    cmd,
    output phij_pkg::status_t                 status,
    output phij_pkg::out_item_t               out_data
);
    import phij_pkg::*;

    logic [TIMER_W-1:0]  pulse_width_reg, peak_time_reg, hold_time_reg;
    logic [PWM_W-1:0]    hold_period_reg, hold_on_reg;
    logic [STIMER_W-1:0] interval_reg;
    logic [ADC_W-1:0]    zero_code_reg;

    logic [1:0]          phase_reg, phase_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic                mode_reg, mode_next;
    logic [TIMER_W-1:0]  ptimer_reg, ptimer_next;
    logic [PWM_W-1:0]    pwm_timer_reg, pwm_timer_next;
    logic                pwm_on_reg, pwm_on_next;
    logic [STIMER_W-1:0] stimer_reg, stimer_next;
    logic [ADC_W-1:0]    peak_reg, peak_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  total_reg, total_next;

    out_item_t           res_reg, res_next;
    logic                res_div_reg, res_div_next;
    out_item_t           out_reg, out_next;

    logic [ADC_W-1:0]    net;
    logic [STIMER_W-1:0] st_inc;
    logic [TIMER_W-1:0]  pt_inc;
    logic [TIMER_W-1:0]  on_len;
    logic [PWM_W-1:0]    pw_inc;
    logic                finish;
    logic                rej;
    logic                drive_on;
    logic                div_busy;
    logic [ADC_W-1:0]    quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg <= TIMER_W'(20000);
            peak_time_reg   <= TIMER_W'(2000);
            hold_time_reg   <= TIMER_W'(1800);
            hold_period_reg <= PWM_W'(500);
            hold_on_reg     <= PWM_W'(250);
            interval_reg    <= STIMER_W'(50);
            zero_code_reg   <= ADC_W'(512);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PULSE_WIDTH:     pulse_width_reg <= cfg_wdata[TIMER_W-1:0];
                REG_PEAK_TIME:       peak_time_reg   <= cfg_wdata[TIMER_W-1:0];
                REG_HOLD_TIME:       hold_time_reg   <= cfg_wdata[TIMER_W-1:0];
                REG_HOLD_PERIOD:     hold_period_reg <= cfg_wdata[PWM_W-1:0];
                REG_HOLD_ON:         hold_on_reg     <= cfg_wdata[PWM_W-1:0];
                REG_SAMPLE_INTERVAL: interval_reg    <= cfg_wdata[STIMER_W-1:0];
                REG_ZERO_CODE:       zero_code_reg   <= cfg_wdata[ADC_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        ch_next        = ch_reg;
        mode_next      = mode_reg;
        ptimer_next    = ptimer_reg;
        pwm_timer_next = pwm_timer_reg;
        pwm_on_next    = pwm_on_reg;
        stimer_next    = stimer_reg;
        peak_next      = peak_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        finish         = 1'b0;
        rej            = 1'b0;

        net    = (in_data.adc_sample > zero_code_reg) ?
                 in_data.adc_sample - zero_code_reg : '0;
        st_inc = stimer_reg + 1'b1;
        pt_inc = ptimer_reg + 1'b1;
        pw_inc = pwm_timer_reg + 1'b1;
        on_len = mode_reg ? peak_time_reg : pulse_width_reg;

        if (in_data.op == OP_START)
        begin
            if (phase_reg != PH_IDLE ||
                {1'b0, in_data.channel} >= (CH_W+1)'(CHANNELS))
            begin
                rej = 1'b1;
            end
            else
            begin
                phase_next     = PH_ON;
                ch_next        = in_data.channel;
                mode_next      = in_data.peak_hold;
                ptimer_next    = '0;
                pwm_timer_next = '0;
                pwm_on_next    = 1'b0;
                stimer_next    = '0;
                peak_next      = '0;
                sum_next       = '0;
                total_next     = '0;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (stimer_reg == '0)
            begin
                if (net > peak_reg)
                begin
                    peak_next = net;
                end
                if (total_reg < COUNT_MAX)
                begin
                    total_next = total_reg + 1'b1;
                    sum_next   = sum_reg + SUM_W'(net);
                end
            end
            stimer_next = (st_inc >= interval_reg) ? '0 : st_inc;
            ptimer_next = pt_inc;
            if (phase_reg == PH_ON)
            begin
                if (pt_inc >= on_len)
                begin
                    if (mode_reg && hold_time_reg != '0)
                    begin
                        phase_next     = PH_HOLD;
                        ptimer_next    = '0;
                        pwm_timer_next = '0;
                        pwm_on_next    = (hold_on_reg != '0);
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            else
            begin
                pwm_timer_next = (pw_inc >= hold_period_reg) ? '0 : pw_inc;
                pwm_on_next    = (pwm_timer_next < hold_on_reg);
                if (pt_inc >= hold_time_reg)
                begin
                    finish = 1'b1;
                end
            end
            if (finish)
            begin
                phase_next  = PH_IDLE;
                pwm_on_next = 1'b0;
            end
        end

        drive_on = (phase_next == PH_ON) || (phase_next == PH_HOLD && pwm_on_next);

        res_next              = '0;
        res_next.drive        = drive_on ? DRIVE_W'(1) << ch_next : '0;
        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.done_res     = finish;
        res_next.rejected     = rej;
        res_next.peak_counts  = finish ? peak_next : '0;
        res_next.sample_count = finish ? total_next : '0;
        res_div_next          = finish && (total_next != '0);
    end

    always_comb
    begin
        out_next            = res_reg;
        out_next.avg_counts = res_div_reg ? quotient : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ch_reg        <= '0;
            mode_reg      <= 1'b0;
            ptimer_reg    <= '0;
            pwm_timer_reg <= '0;
            pwm_on_reg    <= 1'b0;
            stimer_reg    <= '0;
            peak_reg      <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
        end
        else if (cmd.step)
        begin
            phase_reg     <= phase_next;
            ch_reg        <= ch_next;
            mode_reg      <= mode_next;
            ptimer_reg    <= ptimer_next;
            pwm_timer_reg <= pwm_timer_next;
            pwm_on_reg    <= pwm_on_next;
            stimer_reg    <= stimer_next;
            peak_reg      <= peak_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            res_reg     <= res_next;
            res_div_reg <= res_div_next;
        end
        if (cmd.load)
        begin
            out_reg <= out_next;
        end
    end

    phij_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.step && res_div_next),
        .dividend (sum_next),
        .divisor  (total_next),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.need_div = res_div_next;
    assign status.div_busy = div_busy;
    assign out_data        = out_reg;

endmodule

FILE: design/phij_ctrl.sv
// Controller: item sequencing, divider wait and output register handshake.
module phij_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  phij_pkg::status_t  status,
    output phij_pkg::cmd_t     cmd
);
    import phij_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.step       = 1'b0;
        cmd.load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.step   = 1'b1;
                    state_next = status.need_div ? S_DIV : S_LOAD;
                end
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: tb/sv/phij_checker.sv
// Checker for the injector pulse unit: predicts each output item and compares it with the block.
module phij_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  phij_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  phij_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [phij_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phij_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending,
    output int                              items_in,
    output int                              firings_done,
    output int                              starts_rejected,
    output int                              saturated
);
    timeunit 1ns;
    timeprecision 1ps;
    import phij_pkg::*;

    logic [TIMER_W-1:0]  pulse_len;
    logic [TIMER_W-1:0]  peak_len;
    logic [TIMER_W-1:0]  hold_len;
    logic [PWM_W-1:0]    pwm_period;
    logic [PWM_W-1:0]    pwm_on_len;
    logic [STIMER_W-1:0] sample_every;
    logic [ADC_W-1:0]    zero_level;

    logic [1:0]          phase_q;
    logic [CH_W-1:0]     chan_q;
    logic                hold_mode_q;
    logic [TIMER_W-1:0]  phase_ticks;
    logic [PWM_W-1:0]    pwm_ticks;
    logic                pwm_high;
    logic [STIMER_W-1:0] sample_ticks;
    logic [ADC_W-1:0]    peak_net;
    logic [SUM_W-1:0]    net_sum;
    logic [COUNT_W-1:0]  net_count;

    out_item_t           awaited_outputs[$];
    out_item_t           want;
    out_item_t           fresh;
    int                  errors;
    int                  outputs_seen;
    int                  n_in;
    int                  n_done;
    int                  n_rej;
    int                  n_sat;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("mismatch at output %0d, %s: got %0h, expected %0h",
                 outputs_seen, what, got, exp_val);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            flag_mismatch(what, got, exp_val);
    endtask

    function automatic out_item_t advance_injector(input in_item_t it);
        out_item_t          r;
        logic               finish;
        logic [ADC_W-1:0]   net;
        logic [TIMER_W-1:0] span;
        r = '0;
        if (it.op == OP_START)
        begin
            if (phase_q != PH_IDLE || int'(it.channel) >= CHANNELS)
                r.rejected = 1'b1;
            else
            begin
                phase_q      = PH_ON;
                chan_q       = it.channel;
                hold_mode_q  = it.peak_hold;
                phase_ticks  = '0;
                pwm_ticks    = '0;
                pwm_high     = 1'b0;
                sample_ticks = '0;
                peak_net     = '0;
                net_sum      = '0;
                net_count    = '0;
            end
        end
        else if (phase_q != PH_IDLE)
        begin
            finish = 1'b0;
            if (sample_ticks == '0)
            begin
                net = (it.adc_sample > zero_level) ? it.adc_sample - zero_level : '0;
                if (net > peak_net)
                    peak_net = net;
                if (net_count != COUNT_MAX)
                begin
                    net_count = net_count + 1'b1;
                    net_sum   = net_sum + SUM_W'(net);
                end
            end
            sample_ticks = sample_ticks + 1'b1;
            if (sample_ticks >= sample_every)
                sample_ticks = '0;
            phase_ticks = phase_ticks + 1'b1;
            if (phase_q == PH_ON)
            begin
                span = hold_mode_q ? peak_len : pulse_len;
                if (phase_ticks >= span)
                begin
                    if (hold_mode_q && hold_len != '0)
                    begin
                        phase_q     = PH_HOLD;
                        phase_ticks = '0;
                        pwm_ticks   = '0;
                        pwm_high    = (pwm_on_len != '0);
                    end
                    else
                        finish = 1'b1;
                end
            end
            else
            begin
                pwm_ticks = pwm_ticks + 1'b1;
                if (pwm_ticks >= pwm_period)
                    pwm_ticks = '0;
                pwm_high = (pwm_ticks < pwm_on_len);
                if (phase_ticks >= hold_len)
                    finish = 1'b1;
            end
            if (finish)
            begin
                phase_q         = PH_IDLE;
                pwm_high        = 1'b0;
                r.done_res      = 1'b1;
                r.peak_counts   = peak_net;
                r.sample_count  = net_count;
                r.avg_counts    = (net_count != '0) ? ADC_W'(net_sum / net_count) : '0;
            end
        end
        if (phase_q == PH_ON || (phase_q == PH_HOLD && pwm_high))
            r.drive = DRIVE_W'(1) << chan_q;
        r.busy_res = (phase_q != PH_IDLE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_len    = 17'd20000;
            peak_len     = 17'd2000;
            hold_len     = 17'd1800;
            pwm_period   = 16'd500;
            pwm_on_len   = 16'd250;
            sample_every = 10'd50;
            zero_level   = 10'd512;
            phase_q      = PH_IDLE;
            chan_q       = '0;
            hold_mode_q  = 1'b0;
            phase_ticks  = '0;
            pwm_ticks    = '0;
            pwm_high     = 1'b0;
            sample_ticks = '0;
            peak_net     = '0;
            net_sum      = '0;
            net_count    = '0;
            awaited_outputs.delete();
            errors       = 0;
            outputs_seen = 0;
            n_in         = 0;
            n_done       = 0;
            n_rej        = 0;
            n_sat        = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_outputs.size() == 0)
                    flag_mismatch("output with none expected", 32'(out_data), '0);
                else
                begin
                    want = awaited_outputs.pop_front();
                    check_field("drive", 32'(out_data.drive), 32'(want.drive));
                    check_field("busy_res", 32'(out_data.busy_res), 32'(want.busy_res));
                    check_field("done_res", 32'(out_data.done_res), 32'(want.done_res));
                    check_field("rejected", 32'(out_data.rejected), 32'(want.rejected));
                    check_field("peak_counts", 32'(out_data.peak_counts),
                                32'(want.peak_counts));
                    check_field("avg_counts", 32'(out_data.avg_counts),
                                32'(want.avg_counts));
                    check_field("sample_count", 32'(out_data.sample_count),
                                32'(want.sample_count));
                end
                outputs_seen++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PULSE_WIDTH:     pulse_len    = cfg_wdata;
                    REG_PEAK_TIME:       peak_len     = cfg_wdata;
                    REG_HOLD_TIME:       hold_len     = cfg_wdata;
                    REG_HOLD_PERIOD:     pwm_period   = cfg_wdata[PWM_W-1:0];
                    REG_HOLD_ON:         pwm_on_len   = cfg_wdata[PWM_W-1:0];
                    REG_SAMPLE_INTERVAL: sample_every = cfg_wdata[STIMER_W-1:0];
                    REG_ZERO_CODE:       zero_level   = cfg_wdata[ADC_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                fresh = advance_injector(in_data);
                awaited_outputs.push_back(fresh);
                n_in++;
                if (fresh.done_res)
                    n_done++;
                if (fresh.rejected)
                    n_rej++;
                if (fresh.done_res && fresh.sample_count == COUNT_MAX)
                    n_sat++;
            end
        end
        fail_count      <= errors;
        pending         <= awaited_outputs.size();
        items_in        <= n_in;
        firings_done    <= n_done;
        starts_rejected <= n_rej;
        saturated       <= n_sat;
    end

endmodule

FILE: tb/sv/peak_hold_injector_pulse_unit_tb.sv
// Testbench top for the injector pulse unit: clock, reset, stimulus and verdict.
module peak_hold_injector_pulse_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import phij_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SPIN_LIMIT     = 5000;
    localparam int MODE_PLAIN     = 0;
    localparam int MODE_HOLD      = 1;
    localparam int MODE_MIX       = 2;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int items_in;
    int firings_done;
    int starts_rejected;
    int saturated;

    logic steady = 1'b0;
    logic last_busy = 1'b0;
    int   idle_run = 0;
    int   settings_used = 0;

    int cur_pw     = 20000;
    int cur_peak   = 2000;
    int cur_hold   = 1800;
    int cur_zero   = 512;

    peak_hold_injector_pulse_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    phij_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .items_in        (items_in),
        .firings_done    (firings_done),
        .starts_rejected (starts_rejected),
        .saturated       (saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 8);

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            last_busy <= out_data.busy_res;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [ADC_W-1:0] pick_adc();
        int sel;
        int v;
        sel = $urandom_range(7);
        case (sel)
            0: v = 0;
            1: v = (1 << ADC_W) - 1;
            2, 3:
            begin
                v = cur_zero + $urandom_range(16) - 8;
                if (v < 0)
                    v = 0;
                if (v > (1 << ADC_W) - 1)
                    v = (1 << ADC_W) - 1;
            end
            default: v = $urandom_range((1 << ADC_W) - 1);
        endcase
        return ADC_W'(v);
    endfunction

    task automatic send_item(input logic op, input logic [CH_W-1:0] ch, input logic ph,
                             input logic [ADC_W-1:0] adc);
        in_item_t item;
        item.op         = op;
        item.channel    = ch;
        item.peak_hold  = ph;
        item.adc_sample = adc;
        if (!steady && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic tick();
        send_item(OP_TICK, CH_W'($urandom_range(3)), 1'($urandom_range(1)), pick_adc());
    endtask

    // hold the sender until every predicted item has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic finish_firing();
        int spins;
        spins = 0;
        settle();
        while (last_busy && spins < SPIN_LIMIT)
        begin
            tick();
            settle();
            spins++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge clk);
    endtask

    task automatic write_settings(input int pw, input int peak, input int hold,
                                  input int period, input int on_len, input int every,
                                  input int zero);
        finish_firing();
        repeat (30) @(posedge clk);
        write_reg(REG_PULSE_WIDTH, pw);
        write_reg(REG_PEAK_TIME, peak);
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_HOLD_PERIOD, period);
        write_reg(REG_HOLD_ON, on_len);
        write_reg(REG_SAMPLE_INTERVAL, every);
        write_reg(REG_ZERO_CODE, zero);
        cfg_we   <= 1'b0;
        cur_pw   = pw;
        cur_peak = peak;
        cur_hold = hold;
        cur_zero = zero;
        settings_used++;
    endtask

    task automatic fire(input int mode_sel, output int n);
        logic hold_sel;
        int   span;
        hold_sel = (mode_sel == MODE_MIX) ? 1'($urandom_range(1)) : (mode_sel == MODE_HOLD);
        send_item(OP_START, CH_W'($urandom_range(3)), hold_sel, pick_adc());
        n = 1;
        if (hold_sel)
            span = (cur_peak == 0 ? 1 : cur_peak) + cur_hold;
        else
            span = (cur_pw == 0 ? 1 : cur_pw);
        for (int k = 0; k < span; k++)
        begin
            if ($urandom_range(99) < 4)
            begin
                send_item(OP_START, CH_W'($urandom_range(3)),
                          (mode_sel == MODE_MIX) ? 1'($urandom_range(1)) : hold_sel,
                          pick_adc());
                n++;
            end
            // drop out of the firing early now and then
            if ($urandom_range(299) == 0)
                break;
            tick();
            n++;
        end
        if ($urandom_range(99) < 10)
            tick();
    endtask

    task automatic run_phase(input int budget, input int mode_sel);
        int got;
        int total;
        total = 0;
        while (total < budget)
        begin
            fire(mode_sel, got);
            total += got;
            if ($urandom_range(39) == 0)
                settle();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // run on the reset values for a while, then shorten the firing
        send_item(OP_START, 2'd1, 1'b1, pick_adc());
        repeat (120) tick();
        settle();
        write_reg(REG_PEAK_TIME, 1);
        write_reg(REG_HOLD_TIME, 1);
        cfg_we <= 1'b0;
        finish_firing();

        write_settings(2, 1, 3, 2, 1, 1, 0);
        send_item(OP_TICK, 2'd3, 1'b1, 10'h3FF);
        send_item(OP_START, 2'd0, 1'b0, 10'h000);
        send_item(OP_START, 2'd2, 1'b1, 10'h3FF);
        send_item(OP_TICK, 2'd0, 1'b0, 10'h3FF);
        send_item(OP_TICK, 2'd0, 1'b0, 10'h000);
        send_item(OP_START, 2'd3, 1'b1, 10'h155);
        send_item(OP_TICK, 2'd3, 1'b1, 10'h155);
        send_item(OP_TICK, 2'd3, 1'b1, 10'h2AA);
        send_item(OP_TICK, 2'd3, 1'b1, 10'h3FF);
        send_item(OP_TICK, 2'd3, 1'b1, 10'h000);
        send_item(OP_START, 2'd1, 1'b0, 10'h2AA);
        send_item(OP_TICK, 2'd1, 1'b0, 10'h005);
        send_item(OP_TICK, 2'd1, 1'b0, 10'h007);
        send_item(OP_START, 2'd2, 1'b1, 10'h001);
        repeat (4) tick();

        write_settings(0, 0, 0, 0, 0, 0, 1023);
        run_phase(60, MODE_MIX);

        for (int idx = 0; idx < 8; idx++)
        begin
            steady = (idx == 3);
            write_settings($urandom_range(12, 1), $urandom_range(6), $urandom_range(16),
                           $urandom_range(7, 1), $urandom_range(8), $urandom_range(5),
                           $urandom_range(1023));
            run_phase(70, MODE_MIX);
        end
        steady = 1'b0;

        write_settings($urandom_range(8, 1), $urandom_range(6, 1), 20, 3, 7, 2,
                       $urandom_range(1023));
        run_phase(60, MODE_HOLD);
        write_settings(5, 2, 12, 4, 0, 3, 300);
        run_phase(50, MODE_HOLD);
        write_settings(3, 2, 10, 0, 1, 1, 600);
        run_phase(50, MODE_HOLD);
        write_settings(17'h1FFFF, 3, 10, 16'hFFFF, 16'hFFFE, 10'h3FF, 0);
        run_phase(60, MODE_HOLD);
        write_settings(9, 1, 1, 2, 1, 0, $urandom_range(1023));
        run_phase(40, MODE_PLAIN);

        finish_firing();
        repeat (40) @(posedge clk);
        $display("summary: %0d items over %0d register settings plus the reset values",
                 items_in, settings_used);
        $display("summary: %0d firings ended, %0d starts turned away, %0d hit the count limit",
                 firings_done, starts_rejected, saturated);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: peak_hold_injector_pulse_unit.f
design/phij_pkg.sv
design/phij_div.sv
design/phij_dp.sv
design/phij_ctrl.sv
design/peak_hold_injector_pulse_unit.sv
tb/sv/phij_checker.sv
tb/sv/peak_hold_injector_pulse_unit_tb.sv
